[design/rrt_pkg.sv]
`timescale 1ns / 1ps

package rrt_pkg;

    localparam int CAPACITY = 256;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int GROUP    = 16;
    localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;
    localparam int USED_W   = 9;

    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_RESERVE = 2'd1;
    localparam logic [1:0] MODE_CLAIM   = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
    } t_in_word;

    typedef struct packed {
        logic              granted;
        logic              stored;
        logic [USED_W-1:0] used_count;
    } t_out_word;

    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
    } t_box;

    typedef struct packed {
        logic load;
        logic occupied;
    } t_cell_ctrl;

    function automatic t_box form_box(input t_in_word w);
        t_box       b;
        logic [15:0] ex;
        logic [15:0] ey;
        ex   = 16'(unsigned'(w.left)) + {1'b0, w.width} - 16'd1;
        ey   = 16'(unsigned'(w.top)) + {1'b0, w.height} - 16'd1;
        b.x0 = w.left;
        b.y0 = w.top;
        b.x1 = signed'(ex);
        b.y1 = signed'(ey);
        return b;
    endfunction

endpackage

[design/rrt_cell.sv]
`timescale 1ns / 1ps

module rrt_cell import rrt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_box       i_query,
    input  t_box       i_prev,
    output t_box       o_box,
    output logic       o_hit
);

    t_box r_box;
    logic r_hit;
    logic n_hit;

    always_comb begin
        n_hit = i_ctrl.occupied &&
                (i_query.x0 <= r_box.x1) && (i_query.x1 >= r_box.x0) &&
                (i_query.y0 <= r_box.y1) && (i_query.y1 >= r_box.y0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_box <= i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_box = r_box;
    assign o_hit = r_hit;

endmodule

[design/rect_reservation_table_top.sv]
// Reservation table of screen rectangles held in a row of cells, one box per cell. A new box
// enters the first cell and every held box moves one cell along, so the held boxes always fill
// the front of the row. Before the next word is accepted, a word passes these steps in order:
// the box is latched; every cell compares it against its own box in parallel; a registered OR
// tree reduces the cell hits (groups of sixteen, then the groups); the result is decided and
// the count updated, waiting while a held result is stalled. The row shifts at the following
// edge, while the next word is latched. The result sits in an output register, so the next
// word is taken while a result is still stalled. The table needs no clearing after reset.
`timescale 1ns / 1ps

module rect_reservation_table_top import rrt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HIT,
        S_RED1,
        S_RED2,
        S_DONE
    } t_state;

    t_state                r_state;
    t_box                  r_query;
    logic [1:0]            r_mode;
    logic                  r_empty;
    logic [CNT_W-1:0]      r_count;
    logic                  r_load;
    logic                  r_out_valid;
    t_out_word             r_out_word;
    logic [NGROUP-1:0]     r_grp;
    logic                  r_clash;

    t_box                  w_box  [CAPACITY];
    logic [CAPACITY-1:0]   w_hit;
    t_cell_ctrl            w_ctrl [CAPACITY];
    logic [NGROUP*GROUP-1:0] w_hit_pad;

    logic                  n_granted;
    logic                  n_stored;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W+USED_W-1:0] w_count_ext;
    logic                  w_full;
    logic                  w_done;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign w_ctrl[gi].load     = r_load;
            assign w_ctrl[gi].occupied = (r_count > CNT_W'(gi));
            if (gi == 0) begin : g_head
                rrt_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (w_ctrl[gi]),
                    .i_query (r_query),
                    .i_prev  (r_query),
                    .o_box   (w_box[gi]),
                    .o_hit   (w_hit[gi])
                );
            end else begin : g_body
                rrt_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (w_ctrl[gi]),
                    .i_query (r_query),
                    .i_prev  (w_box[gi-1]),
                    .o_box   (w_box[gi]),
                    .o_hit   (w_hit[gi])
                );
            end
        end
        for (gi = 0; gi < NGROUP*GROUP; gi++) begin : g_pad
            if (gi < CAPACITY) begin : g_real
                assign w_hit_pad[gi] = w_hit[gi];
            end else begin : g_zero
                assign w_hit_pad[gi] = 1'b0;
            end
        end
        for (gi = 0; gi < NGROUP; gi++) begin : g_grp
            always_ff @(posedge i_clk) begin
                r_grp[gi] <= |w_hit_pad[gi*GROUP +: GROUP];
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_clash <= |r_grp;
    end

    assign w_full = (r_count == CNT_W'(CAPACITY));
    assign w_done = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_granted = 1'b0;
        n_stored  = 1'b0;
        n_count   = r_count;
        unique case (r_mode)
            MODE_CLEAR: begin
                n_granted = 1'b1;
                n_count   = '0;
            end
            MODE_RESERVE: begin
                n_granted = 1'b1;
                n_stored  = !r_empty && !w_full;
            end
            MODE_CLAIM: begin
                if (r_empty) begin
                    n_granted = 1'b1;
                end else begin
                    n_stored  = !r_clash && !w_full;
                    n_granted = n_stored;
                end
            end
            default: begin
                n_granted = 1'b0;
            end
        endcase
        if (n_stored) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    assign w_count_ext = {{USED_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_load      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_load <= w_done && n_stored;
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_query <= form_box(i_in_word);
                        r_mode  <= i_in_word.mode;
                        r_empty <= (i_in_word.width == '0) || (i_in_word.height == '0);
                        r_state <= S_HIT;
                    end
                end
                S_HIT: begin
                    r_state <= S_RED1;
                end
                S_RED1: begin
                    r_state <= S_RED2;
                end
                S_RED2: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_done) begin
                        r_out_word.granted    <= n_granted;
                        r_out_word.stored     <= n_stored;
                        r_out_word.used_count <= w_count_ext[USED_W-1:0];
                        r_count               <= n_count;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[design/rrt_checker.sv]
`timescale 1ns / 1ps

module rrt_checker import rrt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("Stalled output word changed.");

    a_stored_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.stored |-> o_out_word.granted)
        else $error("Stored box was not granted.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Input taken while a word was still in work.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

endmodule

bind rect_reservation_table_top rrt_checker u_rrt_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import rrt_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  in_word = '0;
    logic      o_out_valid;
    logic      out_stall = 1'b0;
    t_out_word o_out_word;

    rect_reservation_table_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    always #6 i_clk = ~i_clk;

    t_in_word  pending_words[$];
    t_out_word expected_results[$];

    t_box held_boxes[CAPACITY];
    int   held_count = 0;

    int words_queued = 0;
    int words_accepted = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int boxes_stored = 0;
    int claims_refused = 0;
    int full_hits = 0;

    logic in_taken = 1'b0;
    logic feed_done = 1'b0;
    logic calm = 1'b0;
    int   send_rate = 0;
    int   stall_rate = 0;
    int   send_gap = 0;
    int   stall_left = 0;

    t_out_word grant_prediction;
    t_out_word grant_wanted;

    task automatic apply_request(input t_in_word w, output t_out_word r);
        t_box        nb;
        logic [15:0] ex;
        logic [15:0] ey;
        logic        hollow;
        logic        clash;
        hollow = (w.width == 15'd0) || (w.height == 15'd0);
        ex = unsigned'(w.left) + {1'b0, w.width} - 16'd1;
        ey = unsigned'(w.top) + {1'b0, w.height} - 16'd1;
        nb.x0 = w.left;
        nb.y0 = w.top;
        nb.x1 = signed'(ex);
        nb.y1 = signed'(ey);
        r = '0;
        case (w.mode)
            MODE_CLEAR: begin
                held_count = 0;
                r.granted = 1'b1;
            end
            MODE_RESERVE: begin
                r.granted = 1'b1;
                if (!hollow) begin
                    if (held_count < CAPACITY) begin
                        held_boxes[held_count] = nb;
                        held_count++;
                        boxes_stored++;
                        r.stored = 1'b1;
                    end else begin
                        full_hits++;
                    end
                end
            end
            MODE_CLAIM: begin
                if (hollow) begin
                    r.granted = 1'b1;
                end else begin
                    clash = 1'b0;
                    for (int i = 0; i < held_count; i++) begin
                        if (nb.x0 <= held_boxes[i].x1 && nb.x1 >= held_boxes[i].x0 &&
                            nb.y0 <= held_boxes[i].y1 && nb.y1 >= held_boxes[i].y0)
                            clash = 1'b1;
                    end
                    if (!clash && held_count < CAPACITY) begin
                        held_boxes[held_count] = nb;
                        held_count++;
                        boxes_stored++;
                        r.granted = 1'b1;
                        r.stored = 1'b1;
                    end else begin
                        claims_refused++;
                        if (!clash)
                            full_hits++;
                    end
                end
            end
            default: ;
        endcase
        r.used_count = USED_W'(held_count);
    endtask

    task automatic note_mismatch(input string what, input int wanted, input int seen);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("result %0d: %s expected %0d, got %0d", results_checked, what, wanted, seen);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                apply_request(in_word, grant_prediction);
                expected_results.push_back(grant_prediction);
                in_taken = 1'b1;
                words_accepted++;
                if (words_accepted % 100 == 0) begin
                    send_rate = $urandom_range(0, 3);
                    stall_rate = $urandom_range(0, 3);
                end
            end
            if (o_out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected result, used_count", -1,
                                  int'(o_out_word.used_count));
                end else begin
                    grant_wanted = expected_results.pop_front();
                    if (o_out_word.granted !== grant_wanted.granted)
                        note_mismatch("granted", int'(grant_wanted.granted),
                                      int'(o_out_word.granted));
                    if (o_out_word.stored !== grant_wanted.stored)
                        note_mismatch("stored", int'(grant_wanted.stored),
                                      int'(o_out_word.stored));
                    if (o_out_word.used_count !== grant_wanted.used_count)
                        note_mismatch("used_count", int'(grant_wanted.used_count),
                                      int'(o_out_word.used_count));
                end
                results_checked++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            calm = feed_done && (pending_words.size() < 120);
            if (!in_valid || in_taken) begin
                if (send_gap > 0) begin
                    in_valid <= 1'b0;
                    send_gap--;
                end else if (!calm && send_rate != 0 && $urandom_range(0, 9) < send_rate) begin
                    in_valid <= 1'b0;
                    send_gap = $urandom_range(0, 5);
                end else if (pending_words.size() != 0) begin
                    in_valid <= 1'b1;
                    in_word <= pending_words.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
            in_taken = 1'b0;
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if (!calm && stall_rate != 0 && $urandom_range(0, 9) < stall_rate) begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 5);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic t_in_word make_word(input logic [1:0] m, input int l, input int t,
                                           input int w, input int h);
        t_in_word r;
        r.mode = m;
        r.left = 16'(l);
        r.top = 16'(t);
        r.width = 15'(w);
        r.height = 15'(h);
        return r;
    endfunction

    task automatic push_word(input t_in_word w);
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_local(input logic [1:0] m);
        int l;
        int t;
        l = int'($urandom_range(0, 600)) - 300;
        t = int'($urandom_range(0, 600)) - 300;
        if ($urandom_range(0, 7) == 0)
            l = 32767 - int'($urandom_range(0, 60));
        if ($urandom_range(0, 7) == 0)
            t = 32767 - int'($urandom_range(0, 60));
        push_word(make_word(m, l, t, $urandom_range(1, 48), $urandom_range(1, 48)));
    endtask

    task automatic push_noise(input logic [1:0] m);
        push_word(make_word(m, $urandom, $urandom, $urandom, $urandom));
    endtask

    task automatic push_fill_frame();
        push_word(make_word(MODE_CLEAR, 0, 0, 0, 0));
        repeat (245) push_local(MODE_RESERVE);
        for (int i = 0; i < 20; i++)
            push_word(make_word(MODE_CLAIM, 10000 + 20 * i, 12000, 10, $urandom_range(1, 9)));
        repeat (3) push_local(MODE_RESERVE);
        push_local(MODE_CLAIM);
        push_word(make_word(MODE_CLAIM, 20000, 20000, 0, 7));
        push_word(make_word(MODE_RESERVE, -5000, 7, 9, 0));
        push_noise(MODE_UNUSED);
    endtask

    task automatic push_mixed_frame();
        int pick;
        if ($urandom_range(0, 3) != 0)
            push_word(make_word(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom));
        repeat ($urandom_range(20, 60)) begin
            pick = $urandom_range(0, 19);
            if (pick <= 12)
                push_local(MODE_CLAIM);
            else if (pick <= 15)
                push_local(MODE_RESERVE);
            else if (pick == 16)
                push_word(make_word($urandom_range(1, 2) == 1 ? MODE_RESERVE : MODE_CLAIM,
                                    $urandom, $urandom,
                                    $urandom_range(0, 1) ? 0 : $urandom_range(0, 32767),
                                    $urandom_range(0, 1) ? $urandom_range(0, 32767) : 0));
            else if (pick == 17)
                push_noise(MODE_UNUSED);
            else if (pick == 18)
                push_noise(2'($urandom_range(0, 3)));
            else
                push_noise(MODE_CLAIM);
        end
    endtask

    task automatic push_random_frames(input int goal, input int fills_wanted);
        int fills;
        fills = 0;
        while (words_queued < goal) begin
            if (fills < fills_wanted && (fills == 0 || $urandom_range(0, 5) == 0)) begin
                push_fill_frame();
                fills++;
            end else if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(10, 30)) push_noise(2'($urandom_range(0, 3)));
            end else begin
                push_mixed_frame();
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_word(make_word(MODE_CLEAR, 0, 0, 0, 0));
        push_word(make_word(MODE_RESERVE, -32768, -32768, 1, 1));
        push_word(make_word(MODE_RESERVE, 32767, 32767, 1, 1));
        push_word(make_word(MODE_CLAIM, -32768, -32768, 1, 1));
        push_word(make_word(MODE_CLAIM, -32767, -32768, 1, 1));
        push_word(make_word(MODE_CLAIM, 100, 100, 10, 10));
        push_word(make_word(MODE_CLAIM, 110, 100, 5, 5));
        push_word(make_word(MODE_CLAIM, 109, 109, 1, 1));
        push_word(make_word(MODE_CLAIM, 100, 110, 10, 3));
        push_word(make_word(MODE_CLAIM, 0, 0, 0, 5));
        push_word(make_word(MODE_RESERVE, 5, 5, 5, 0));
        push_word(make_word(MODE_CLAIM, 32767, 0, 32767, 32767));
        push_word(make_word(MODE_RESERVE, 32000, 32000, 32767, 32767));
        push_word(make_word(MODE_UNUSED, 1, 2, 3, 4));
        push_word(make_word(MODE_CLAIM, -20000, -20000, 32767, 32767));
        push_word(make_word(MODE_RESERVE, -1, -1, 32767, 32767));
        push_word(make_word(MODE_CLAIM, -1, -1, 2, 2));
        push_word(make_word(MODE_CLEAR, -1, -1, 32767, 32767));
        push_word(make_word(MODE_CLAIM, -1, -1, 2, 2));
        push_word(make_word(MODE_CLAIM, 1, 1, 1, 1));
        push_word(make_word(MODE_CLAIM, 'h5555, 'h2aaa, 'h2aaa, 'h5555));
        push_word(make_word(MODE_UNUSED, -1, -1, 32767, 32767));
        push_word(make_word(MODE_CLAIM, 0, 0, 0, 0));
        wait_drained();

        push_random_frames(words_queued + 850, 1);
        wait_drained();
        repeat (8) @(posedge i_clk);

        push_random_frames(words_queued + 900, 1);
        feed_done = 1'b1;
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Checked %0d results for %0d request words; %0d boxes stored, %0d claims refused.",
                 results_checked, words_accepted, boxes_stored, claims_refused);
        $display("The table was full for %0d non-empty requests.", full_hits);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches in total.", mismatch_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Run timed out with %0d results outstanding.", expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[rect_reservation_table_top.f]
design/rrt_pkg.sv
design/rrt_cell.sv
design/rect_reservation_table_top.sv
design/rrt_checker.sv
tb/tb.sv
